>>> hdl/bmf_pkg.sv
// ----------------------------------------------------------------------------
// bmf_pkg
// Shared types and constants of the zero-padded box mean filter.
// ----------------------------------------------------------------------------
`default_nettype none

package bmf_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam int IMG_W_W    = 11;
    localparam int IMG_H_W    = 13;
    localparam int RAD_W      = 3;
    localparam int PIX_W      = 8;
    localparam int SUM_W      = 16;
    localparam int RECIP_W    = 29;
    localparam int RECIP_SH   = 28;

    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 2'd2;

    typedef struct packed {
        logic wr_en;
        logic emit;
        logic last;
    } bmf_ctl_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_MUL,
        ST_OUT
    } bmf_state_t;

    // ceil(2^28 / (2r+1)^2): exact truncated quotient for any window sum
    function automatic logic [RECIP_W-1:0] bmf_recip(input logic [RAD_W-1:0] r);
        logic [RECIP_W-1:0] m;
        unique case (r)
            3'd0:    m = 29'd268435456;
            3'd1:    m = 29'd29826162;
            3'd2:    m = 29'd10737419;
            3'd3:    m = 29'd5478275;
            3'd4:    m = 29'd3314018;
            3'd5:    m = 29'd2218475;
            3'd6:    m = 29'd1588376;
            3'd7:    m = 29'd1193047;
            default: m = 29'd268435456;
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

>>> hdl/box_mean_filter_zero_pad_core.sv
// Flow: an item that produces a result leaves the queue, then the window engine scans
//   each window tap (ST_SCAN), drains the read (ST_DRAIN), multiplies (ST_MUL) and
//   presents the result (ST_OUT), waiting there while out_stall holds; other items
//   only leave the queue. No new item is taken until the result is handed on.
// Reset: asynchronous, active low; registers return to width 1024, height 1024,
//   radius 1 and frame position zero. Line memory is not cleared.
// ----------------------------------------------------------------------------
// box_mean_filter_zero_pad_core
// Streaming box mean filter with zero padding at the image border.
// ----------------------------------------------------------------------------
`default_nettype none

module box_mean_filter_zero_pad_core import bmf_pkg::*; #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096,
    parameter int MAX_RADIUS = 7
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic                  kind,
    input  wire logic [PIX_W-1:0]      pixel,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [PIX_W-1:0]           blurred,
    output logic                       frame_end
);

    localparam int LINE_DEPTH = 2 * MAX_RADIUS * MAX_WIDTH + 2 * MAX_RADIUS + 1;
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int AW = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
    localparam int PW = $clog2(MAX_WIDTH * MAX_HEIGHT + MAX_RADIUS * MAX_WIDTH
                               + MAX_RADIUS + 1);
    localparam int CTL_W = $bits(bmf_ctl_t);
    localparam int DW = AW + PIX_W + CTL_W + WW + HW;

    logic             q_push;
    logic             q_pop;
    logic             q_full;
    logic             q_empty;
    logic [AW-1:0]    f_addr;
    logic [PIX_W-1:0] f_pixel;
    bmf_ctl_t         f_ctl;
    logic [WW-1:0]    f_col;
    logic [HW-1:0]    f_row;
    logic [DW-1:0]    q_in;
    logic [DW-1:0]    q_out;
    logic [WW-1:0]    eff_w;
    logic [HW-1:0]    eff_h;
    logic [RAD_W-1:0] eff_r;
    logic             cfg_wr;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;
    assign q_in      = {f_addr, f_pixel, f_ctl, f_col, f_row};

    bmf_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_RADIUS (MAX_RADIUS),
        .WW         (WW),
        .HW         (HW),
        .PW         (PW),
        .AW         (AW),
        .LINE_DEPTH (LINE_DEPTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr     (cfg_wr),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .kind       (kind),
        .pixel      (pixel),
        .in_stall   (in_stall),
        .q_full     (q_full),
        .push       (q_push),
        .push_addr  (f_addr),
        .push_pixel (f_pixel),
        .push_ctl   (f_ctl),
        .push_col   (f_col),
        .push_row   (f_row),
        .eff_w      (eff_w),
        .eff_h      (eff_h),
        .eff_r      (eff_r)
    );

    bmf_fifo #(
        .DW (DW)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .pop_data  (q_out),
        .full      (q_full),
        .empty     (q_empty)
    );

    bmf_back #(
        .WW         (WW),
        .HW         (HW),
        .AW         (AW),
        .LINE_DEPTH (LINE_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .pop       (q_pop),
        .q_addr    (q_out[DW-1 -: AW]),
        .q_pixel   (q_out[DW-AW-1 -: PIX_W]),
        .q_ctl     (q_out[WW+HW +: CTL_W]),
        .q_col     (q_out[HW +: WW]),
        .q_row     (q_out[HW-1:0]),
        .eff_w     (eff_w),
        .eff_h     (eff_h),
        .eff_r     (eff_r),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .blurred   (blurred),
        .frame_end (frame_end)
    );

endmodule

`default_nettype wire

>>> hdl/bmf_fifo.sv
// ----------------------------------------------------------------------------
// bmf_fifo
// Two-entry queue between the classifying front and the window engine.
// ----------------------------------------------------------------------------
`default_nettype none

module bmf_fifo import bmf_pkg::*; #(
    parameter int DW = 8
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire logic [DW-1:0] push_data,
    input  wire logic          pop,
    output logic [DW-1:0]      pop_data,
    output logic               full,
    output logic               empty
);

    logic [DW-1:0] slot_reg [2];
    logic          wptr_reg;
    logic          wptr_next;
    logic          rptr_reg;
    logic          rptr_next;
    logic [1:0]    count_reg;
    logic [1:0]    count_next;

    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign pop_data = slot_reg[rptr_reg];

    always_comb
    begin
        wptr_next  = push ? ~wptr_reg : wptr_reg;
        rptr_next  = pop ? ~rptr_reg : rptr_reg;
        count_next = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

>>> hdl/bmf_front.sv
// ----------------------------------------------------------------------------
// bmf_front
// Configuration registers, frame position tracking and item classification.
// ----------------------------------------------------------------------------
`default_nettype none

module bmf_front import bmf_pkg::*; #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096,
    parameter int MAX_RADIUS = 7,
    parameter int WW = 11,
    parameter int HW = 13,
    parameter int PW = 23,
    parameter int AW = 14,
    parameter int LINE_DEPTH = 14351
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_wr,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  in_valid,
    input  wire logic                  kind,
    input  wire logic [PIX_W-1:0]      pixel,
    output logic                       in_stall,
    input  wire logic                  q_full,
    output logic                       push,
    output logic [AW-1:0]              push_addr,
    output logic [PIX_W-1:0]           push_pixel,
    output bmf_ctl_t                   push_ctl,
    output logic [WW-1:0]              push_col,
    output logic [HW-1:0]              push_row,
    output logic [WW-1:0]              eff_w,
    output logic [HW-1:0]              eff_h,
    output logic [RAD_W-1:0]           eff_r
);

    logic [WW-1:0]    w_reg, w_next;
    logic [HW-1:0]    h_reg, h_next;
    logic [RAD_W-1:0] r_reg, r_next;
    logic [PW-1:0]    pos_reg, pos_next;
    logic [AW-1:0]    ptr_reg, ptr_next;
    logic [WW-1:0]    ocol_reg, ocol_next;
    logic [HW-1:0]    orow_reg, orow_next;
    logic [PW-1:0]    frame;
    logic [PW-1:0]    lag;
    logic [PW-1:0]    qpos;
    logic             accept;
    logic             ignore;
    logic             in_zone;
    logic             over;
    logic             emit;
    logic             last;
    logic             restart;
    logic             cfg_hit;

    assign frame    = PW'(w_reg) * PW'(h_reg);
    assign lag      = PW'(r_reg) * PW'(w_reg) + PW'(r_reg);
    assign qpos     = pos_reg - lag;
    assign in_stall = q_full;
    assign accept   = in_valid && !in_stall;
    assign ignore   = kind && (pos_reg == '0);
    assign in_zone  = (pos_reg >= lag);
    assign over     = in_zone && (qpos >= frame);
    assign emit     = in_zone && !over;
    assign last     = emit && (qpos == frame - PW'(1));
    assign restart  = over || last;
    assign cfg_hit  = cfg_wr && (cfg_index == CFG_WIDTH || cfg_index == CFG_HEIGHT
                                 || cfg_index == CFG_RADIUS);

    assign push           = accept && !ignore;
    assign push_addr      = ptr_reg;
    assign push_pixel     = kind ? '0 : pixel;
    assign push_ctl.wr_en = (pos_reg < frame);
    assign push_ctl.emit  = emit;
    assign push_ctl.last  = last;
    assign push_col       = ocol_reg;
    assign push_row       = orow_reg;
    assign eff_w          = w_reg;
    assign eff_h          = h_reg;
    assign eff_r          = r_reg;

    // clamp on write
    always_comb
    begin
        w_next = w_reg;
        h_next = h_reg;
        r_next = r_reg;
        if (cfg_wr)
        begin
            unique case (cfg_index)
                CFG_WIDTH:
                begin
                    if (cfg_data[IMG_W_W-1:0] == '0)
                        w_next = WW'(1);
                    else if (32'(cfg_data[IMG_W_W-1:0]) > MAX_WIDTH)
                        w_next = WW'(MAX_WIDTH);
                    else
                        w_next = WW'(cfg_data[IMG_W_W-1:0]);
                end
                CFG_HEIGHT:
                begin
                    if (cfg_data[IMG_H_W-1:0] == '0)
                        h_next = HW'(1);
                    else if (32'(cfg_data[IMG_H_W-1:0]) > MAX_HEIGHT)
                        h_next = HW'(MAX_HEIGHT);
                    else
                        h_next = HW'(cfg_data[IMG_H_W-1:0]);
                end
                CFG_RADIUS:
                begin
                    if (32'(cfg_data[RAD_W-1:0]) > MAX_RADIUS)
                        r_next = RAD_W'(MAX_RADIUS);
                    else
                        r_next = cfg_data[RAD_W-1:0];
                end
                default:
                begin
                    w_next = w_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        pos_next  = pos_reg;
        ptr_next  = ptr_reg;
        ocol_next = ocol_reg;
        orow_next = orow_reg;
        if (cfg_hit)
        begin
            pos_next  = '0;
            ptr_next  = '0;
            ocol_next = '0;
            orow_next = '0;
        end
        else if (push)
        begin
            if (restart)
            begin
                pos_next  = '0;
                ptr_next  = '0;
                ocol_next = '0;
                orow_next = '0;
            end
            else
            begin
                pos_next = pos_reg + PW'(1);
                ptr_next = (32'(ptr_reg) == LINE_DEPTH - 1) ? '0 : ptr_reg + AW'(1);
                if (emit)
                begin
                    if (ocol_reg == w_reg - WW'(1))
                    begin
                        ocol_next = '0;
                        orow_next = orow_reg + HW'(1);
                    end
                    else
                    begin
                        ocol_next = ocol_reg + WW'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_reg    <= WW'((MAX_WIDTH < 1024) ? MAX_WIDTH : 1024);
            h_reg    <= HW'((MAX_HEIGHT < 1024) ? MAX_HEIGHT : 1024);
            r_reg    <= RAD_W'((MAX_RADIUS < 1) ? MAX_RADIUS : 1);
            pos_reg  <= '0;
            ptr_reg  <= '0;
            ocol_reg <= '0;
            orow_reg <= '0;
        end
        else
        begin
            w_reg    <= w_next;
            h_reg    <= h_next;
            r_reg    <= r_next;
            pos_reg  <= pos_next;
            ptr_reg  <= ptr_next;
            ocol_reg <= ocol_next;
            orow_reg <= orow_next;
        end
    end

endmodule

`default_nettype wire

>>> hdl/bmf_back.sv
// ----------------------------------------------------------------------------
// bmf_back
// Line memory, window scan with zero padding, and reciprocal divide.
// ----------------------------------------------------------------------------
`default_nettype none

module bmf_back import bmf_pkg::*; #(
    parameter int WW = 11,
    parameter int HW = 13,
    parameter int AW = 14,
    parameter int LINE_DEPTH = 14351
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             q_empty,
    output logic                  pop,
    input  wire logic [AW-1:0]    q_addr,
    input  wire logic [PIX_W-1:0] q_pixel,
    input  wire bmf_ctl_t         q_ctl,
    input  wire logic [WW-1:0]    q_col,
    input  wire logic [HW-1:0]    q_row,
    input  wire logic [WW-1:0]    eff_w,
    input  wire logic [HW-1:0]    eff_h,
    input  wire logic [RAD_W-1:0] eff_r,
    output logic                  out_valid,
    input  wire logic             out_stall,
    output logic [PIX_W-1:0]      blurred,
    output logic                  frame_end
);

    localparam int RI = HW + 4;
    localparam int CI = WW + 4;
    localparam int PRW = SUM_W + RECIP_W;

    bmf_state_t state_reg, state_next;

    logic [PIX_W-1:0]     mem [LINE_DEPTH];
    logic [PIX_W-1:0]     rd_data_reg;
    logic                 rd_ok_reg;
    logic [AW-1:0]        base_reg;
    logic [AW-1:0]        dist_reg;
    logic [AW-1:0]        row_dist_reg;
    logic signed [RI-1:0] a_reg;
    logic signed [CI-1:0] b_reg;
    logic signed [CI-1:0] b_start_reg;
    logic [RAD_W:0]       i_reg;
    logic [RAD_W:0]       j_reg;
    logic                 last_reg;
    logic [SUM_W-1:0]     sum_reg;
    logic [PRW-1:0]       prod_reg;
    logic                 out_valid_reg;
    logic [PIX_W-1:0]     blurred_reg;
    logic                 frame_end_reg;

    logic [RAD_W:0]       span;
    logic [AW-1:0]        lag;
    logic [AW:0]          diff;
    logic [AW-1:0]        rd_addr;
    logic                 in_window;
    logic                 scan;
    logic                 row_end;
    logic                 scan_done;
    logic                 load_out;
    logic                 out_free;

    assign span      = {eff_r, 1'b0};
    assign lag       = AW'(eff_r) * AW'(eff_w) + AW'(eff_r);
    assign diff      = {1'b0, base_reg} - {1'b0, dist_reg};
    assign rd_addr   = diff[AW] ? AW'(diff + (AW+1)'(LINE_DEPTH)) : diff[AW-1:0];
    assign in_window = !a_reg[RI-1] && (a_reg[RI-2:0] < (RI-1)'(eff_h))
                       && !b_reg[CI-1] && (b_reg[CI-2:0] < (CI-1)'(eff_w));
    assign row_end   = (j_reg == span);
    assign scan_done = row_end && (i_reg == span);
    assign out_free  = !out_valid_reg || !out_stall;

    assign out_valid = out_valid_reg;
    assign blurred   = blurred_reg;
    assign frame_end = frame_end_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (!q_empty && q_ctl.emit) state_next = ST_SCAN;
            ST_SCAN:  if (scan_done) state_next = ST_DRAIN;
            ST_DRAIN: state_next = ST_MUL;
            ST_MUL:   state_next = ST_OUT;
            ST_OUT:   if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        pop      = 1'b0;
        scan     = 1'b0;
        load_out = 1'b0;
        unique case (state_reg)
            ST_IDLE:  pop = !q_empty;
            ST_SCAN:  scan = 1'b1;
            ST_OUT:   load_out = out_free;
            default:  pop = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            rd_ok_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rd_ok_reg <= scan && in_window;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // line memory: write on pop when wr_en is set, registered read during the scan
    always_ff @(posedge clk)
    begin
        if (pop && q_ctl.wr_en)
            mem[q_addr] <= q_pixel;
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            base_reg     <= q_addr;
            dist_reg     <= AW'({lag, 1'b0});
            row_dist_reg <= AW'({lag, 1'b0});
            a_reg        <= RI'(q_row) - RI'(eff_r);
            b_reg        <= CI'(q_col) - CI'(eff_r);
            b_start_reg  <= CI'(q_col) - CI'(eff_r);
            i_reg        <= '0;
            j_reg        <= '0;
            last_reg     <= q_ctl.last;
            sum_reg      <= '0;
        end
        else
        begin
            if (rd_ok_reg)
                sum_reg <= sum_reg + SUM_W'(rd_data_reg);
            if (scan)
            begin
                if (row_end)
                begin
                    // advance to the next window row
                    dist_reg     <= row_dist_reg - AW'(eff_w);
                    row_dist_reg <= row_dist_reg - AW'(eff_w);
                    a_reg        <= a_reg + RI'(1);
                    b_reg        <= b_start_reg;
                    i_reg        <= i_reg + (RAD_W+1)'(1);
                    j_reg        <= '0;
                end
                else
                begin
                    dist_reg <= dist_reg - AW'(1);
                    b_reg    <= b_reg + CI'(1);
                    j_reg    <= j_reg + (RAD_W+1)'(1);
                end
            end
        end
        if (state_reg == ST_MUL)
            prod_reg <= PRW'(sum_reg) * PRW'(bmf_recip(eff_r));
        if (load_out)
        begin
            blurred_reg   <= prod_reg[RECIP_SH +: PIX_W];
            frame_end_reg <= last_reg;
        end
    end

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SCAN |-> (i_reg <= span) && (j_reg <= span))
        else $error("window scan ran past its edge");

    a_out_from_out_state: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_OUT))
        else $error("result raised outside of the output state");

    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> state_reg == ST_IDLE && !q_empty)
        else $error("queue popped while busy or empty");

    a_sum_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_MUL |-> sum_reg <= SUM_W'(57375))
        else $error("window sum exceeds full window of maximum pixels");

endmodule

`default_nettype wire
